### sv/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants for the RTP H.264 depacketizer.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int unsigned PayloadBits = 16;
  localparam int unsigned MaxResults  = 8;
  localparam int unsigned CountBits   = $clog2(MaxResults + 1);
  localparam int unsigned IndexBits   = $clog2(MaxResults);

  // nal unit type codes carried in the low five bits of the first byte
  localparam logic [4:0] NalSingleMin = 5'd1;
  localparam logic [4:0] NalSingleMax = 5'd23;
  localparam logic [4:0] NalStapA     = 5'd24;
  localparam logic [4:0] NalFuA       = 5'd28;

  // fu header flags
  localparam int unsigned FuStartBit = 7;
  localparam int unsigned FuEndBit   = 6;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_TENT   = 3'd1,
    KIND_DROP   = 3'd2,
    KIND_COMMIT = 3'd3,
    KIND_AUEND  = 3'd4
  } out_kind_t;

  typedef struct packed {
    logic [7:0] data;
    out_kind_t  kind;
  } rhd_res_t;

  typedef struct packed {
    rhd_res_t [MaxResults-1:0] item;
    logic [CountBits-1:0]      count;
  } rhd_list_t;

endpackage

### sv/rhd_in_if.sv
// ----------------------------------------------------------------------------
// rhd_in_if
// Payload byte channel into the depacketizer.
// ----------------------------------------------------------------------------
interface rhd_in_if
  import rhd_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic [7:0]             payload_byte;
  logic                   first_byte;
  logic                   last_byte;
  logic [PayloadBits-1:0] payload_length;
  logic                   rtp_marker;

  modport source (
    output valid, payload_byte, first_byte, last_byte, payload_length, rtp_marker,
    input  ready
  );

  modport sink (
    input  valid, payload_byte, first_byte, last_byte, payload_length, rtp_marker,
    output ready
  );
endinterface

### sv/rhd_out_if.sv
// ----------------------------------------------------------------------------
// rhd_out_if
// Annex B stream channel out of the depacketizer.
// ----------------------------------------------------------------------------
interface rhd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       run_last;

  modport source (
    output valid, out_byte, out_kind, run_last,
    input  ready
  );

  modport sink (
    input  valid, out_byte, out_kind, run_last,
    output ready
  );
endinterface

### sv/rhd_parse.sv
// ----------------------------------------------------------------------------
// rhd_parse
// Packet parser: holds the depacketizer state and turns one payload byte
// into a list of up to eight stream results.
// ----------------------------------------------------------------------------
module rhd_parse
  import rhd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  rhd_in_if.sink     pkt,
  input  logic       take,
  output logic       load,
  output rhd_list_t  lst
);

  localparam int unsigned SumBits = PayloadBits + 2;

  typedef enum logic [2:0] {
    PK_NONE   = 3'd0,
    PK_SINGLE = 3'd1,
    PK_STAP   = 3'd2,
    PK_FU     = 3'd3,
    PK_SKIP   = 3'd4
  } pkt_kind_t;

  typedef enum logic [1:0] {
    PH_SIZE_HI = 2'd0,
    PH_SIZE_LO = 2'd1,
    PH_UNIT    = 2'd2,
    PH_STOP    = 2'd3
  } phase_t;

  pkt_kind_t              kind, kind_next;
  phase_t                 phase, phase_next;
  logic [LENGTH_BITS-1:0] offset, offset_next;
  logic [7:0]             size_hi, size_hi_next;
  logic [LENGTH_BITS-1:0] left, left_next;
  logic [2:0]             nri, nri_next;
  logic                   frag_open, frag_open_next;
  logic                   end_seen, end_seen_next;
  logic                   has_data, has_data_next;

  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] pos;
  logic [PayloadBits-1:0] size;
  logic [4:0]             nal_type;
  logic [CountBits-1:0]   n;
  logic                   active;
  logic                   ends;
  logic                   marker_ok;
  logic [7:0]             b;

  assign pkt.ready = take;
  assign load      = pkt.valid && take;
  assign len       = pkt.payload_length[LENGTH_BITS-1:0];
  assign b         = pkt.payload_byte;
  assign nal_type  = b[4:0];

  always_comb begin
    kind_next      = kind;
    phase_next     = phase;
    offset_next    = offset;
    size_hi_next   = size_hi;
    left_next      = left;
    nri_next       = nri;
    frag_open_next = frag_open;
    end_seen_next  = end_seen;
    has_data_next  = has_data;
    lst            = '0;
    n              = '0;
    active         = 1'b0;
    pos            = '0;
    ends           = 1'b0;
    marker_ok      = 1'b1;
    size           = '0;

    if (pkt.first_byte) begin
      kind_next   = PK_NONE;
      offset_next = '0;
      if (len != '0) begin
        active = 1'b1;
        priority if (nal_type >= NalSingleMin && nal_type <= NalSingleMax) begin
          kind_next = PK_SINGLE;
        end else if (nal_type == NalStapA) begin
          kind_next = PK_STAP;
        end else if (nal_type == NalFuA) begin
          kind_next = PK_FU;
        end else begin
          kind_next = PK_SKIP;
        end
        phase_next    = PH_SIZE_HI;
        end_seen_next = 1'b0;
      end
    end else if (kind != PK_NONE) begin
      active = 1'b1;
    end

    if (active) begin
      pos  = pkt.first_byte ? '0 : offset;
      ends = pkt.last_byte ||
             ({1'b0, pos} + {{LENGTH_BITS{1'b0}}, 1'b1} >= {1'b0, len});

      unique case (kind_next)
        PK_SINGLE: begin
          if (pos == '0) begin
            for (int i = 0; i < 4; i++) begin
              lst.item[n[IndexBits-1:0]] = '{data: (i == 3) ? 8'h01 : 8'h00,
                                             kind: KIND_DATA};
              n = n + 1'b1;
            end
          end
          lst.item[n[IndexBits-1:0]] = '{data: b, kind: KIND_DATA};
          n = n + 1'b1;
          has_data_next = 1'b1;
        end
        PK_STAP: begin
          if (pos != '0) begin
            unique case (phase_next)
              PH_SIZE_HI: begin
                size_hi_next = b;
                phase_next   = PH_SIZE_LO;
              end
              PH_SIZE_LO: begin
                size = {size_hi, b};
                if (size == '0 ||
                    SumBits'(pos) + SumBits'(1) + SumBits'(size) > SumBits'(len)) begin
                  phase_next = PH_STOP;
                end else begin
                  for (int i = 0; i < 4; i++) begin
                    lst.item[n[IndexBits-1:0]] = '{data: (i == 3) ? 8'h01 : 8'h00,
                                                   kind: KIND_DATA};
                    n = n + 1'b1;
                  end
                  left_next     = size[LENGTH_BITS-1:0];
                  phase_next    = PH_UNIT;
                  has_data_next = 1'b1;
                end
              end
              PH_UNIT: begin
                lst.item[n[IndexBits-1:0]] = '{data: b, kind: KIND_DATA};
                n = n + 1'b1;
                left_next = left - 1'b1;
                if (left == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                  phase_next = PH_SIZE_HI;
                end
              end
              PH_STOP: begin
              end
            endcase
          end
        end
        PK_FU: begin
          if (pos == '0) begin
            nri_next = b[7:5];
            if (ends) begin
              marker_ok = 1'b0;
            end
          end else if (pos == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
            end_seen_next = b[FuEndBit];
            if (b[FuStartBit]) begin
              // a new start drops whatever fragment is still open
              if (frag_open) begin
                lst.item[n[IndexBits-1:0]] = '{data: 8'h00, kind: KIND_DROP};
                n = n + 1'b1;
              end
              frag_open_next = 1'b1;
              for (int i = 0; i < 4; i++) begin
                lst.item[n[IndexBits-1:0]] = '{data: (i == 3) ? 8'h01 : 8'h00,
                                               kind: KIND_TENT};
                n = n + 1'b1;
              end
              lst.item[n[IndexBits-1:0]] = '{data: {nri, b[4:0]}, kind: KIND_TENT};
              n = n + 1'b1;
            end
          end else if (frag_open) begin
            lst.item[n[IndexBits-1:0]] = '{data: b, kind: KIND_TENT};
            n = n + 1'b1;
          end
          if (ends && pos != '0 && end_seen_next && frag_open_next) begin
            lst.item[n[IndexBits-1:0]] = '{data: 8'h00, kind: KIND_COMMIT};
            n = n + 1'b1;
            frag_open_next = 1'b0;
            has_data_next  = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (ends) begin
        if (pkt.rtp_marker && marker_ok) begin
          if (frag_open_next) begin
            lst.item[n[IndexBits-1:0]] = '{data: 8'h00, kind: KIND_DROP};
            n = n + 1'b1;
            frag_open_next = 1'b0;
          end
          if (has_data_next) begin
            lst.item[n[IndexBits-1:0]] = '{data: 8'h00, kind: KIND_AUEND};
            n = n + 1'b1;
            has_data_next = 1'b0;
          end
        end
        kind_next     = PK_NONE;
        end_seen_next = 1'b0;
        offset_next   = '0;
      end else begin
        offset_next = pos + 1'b1;
      end
    end

    lst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind      <= PK_NONE;
      phase     <= PH_SIZE_HI;
      offset    <= '0;
      frag_open <= 1'b0;
      end_seen  <= 1'b0;
      has_data  <= 1'b0;
      size_hi   <= '0;
      left      <= '0;
      nri       <= '0;
    end else if (load) begin
      kind      <= kind_next;
      phase     <= phase_next;
      offset    <= offset_next;
      frag_open <= frag_open_next;
      end_seen  <= end_seen_next;
      has_data  <= has_data_next;
      size_hi   <= size_hi_next;
      left      <= left_next;
      nri       <= nri_next;
    end
  end

endmodule

### sv/rhd_result_buf.sv
// ----------------------------------------------------------------------------
// rhd_result_buf
// Result register: holds the result list of one payload byte and hands it
// out one transaction per cycle while strm is ready.
// ----------------------------------------------------------------------------
module rhd_result_buf
  import rhd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rhd_list_t  lst_in,
  output logic       take,
  rhd_out_if.source  strm
);

  rhd_list_t            lst;
  logic [IndexBits-1:0] idx;
  logic                 loaded;
  logic                 is_last;
  logic                 pop;

  assign is_last = ({1'b0, idx} + 1'b1) == lst.count;
  assign pop     = loaded && strm.ready;
  // free now, or the final result is leaving in this cycle
  assign take    = !loaded || (strm.ready && is_last);

  assign strm.valid    = loaded;
  assign strm.out_byte = lst.item[idx].data;
  assign strm.out_kind = lst.item[idx].kind;
  assign strm.run_last = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      loaded <= (lst_in.count != '0);
      idx    <= '0;
    end else if (pop && is_last) begin
      loaded <= 1'b0;
    end else if (pop) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lst <= lst_in;
    end
  end

endmodule

### sv/rtp_h264_depacketizer.sv
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer
// RTP H.264 payload to Annex B byte stream: single NAL, STAP-A and FU-A
// packets, with tentative fragment output and access unit end marks.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                                           role
//   pkt_in    sink       payload_byte first_byte last_byte payload_length  rtp bytes
//                        rtp_marker
//   strm_out  source     out_byte out_kind run_last                        stream
//
// at most one payload byte is taken per cycle; it yields zero to eight output
// transactions, which the result register hands out one per cycle while strm_out
// is ready, and a byte is taken in the cycle its last result leaves, so plain data
// then runs at one byte per cycle; a start code holds pkt_in until its results
// leave; bytes that yield no result are taken every cycle while strm_out is idle
// rst is synchronous and clears the parser state and the result register
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer
  import rhd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  rhd_in_if.sink     pkt_in,
  rhd_out_if.source  strm_out
);

  // handoff between the parser and the result register
  logic      take;
  logic      load;
  rhd_list_t lst;

  // parser: decodes the packet form and builds the result list for each byte
  rhd_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .pkt  (pkt_in),
    .take (take),
    .load (load),
    .lst  (lst)
  );

  // result register: drains the list, marks the final result of each byte
  rhd_result_buf u_result_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .lst_in (lst),
    .take   (take),
    .strm   (strm_out)
  );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rtp_h264_depacketizer. RTP payload bytes are fed
// through pkt_in: first a directed list of corner cases, then random access
// units built from single NAL, STAP-A, FU-A and skipped packets, with some
// broken lengths and stray bytes. A cycle-free model of the parser predicts
// every Annex B transaction not typed in, and strm_out is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import rhd_pkg::*;

  // one payload byte as it is presented on pkt_in
  typedef struct packed {
    logic [7:0]  pb;
    logic        fb;
    logic        lb;
    logic [15:0] len;
    logic        mk;
  } rtp_byte_t;

  // one stream transaction as it should appear on strm_out
  typedef struct packed {
    logic [7:0] data;
    out_kind_t  kind;
    logic       last;
  } strm_beat_t;

  // directed row; n >= 0 means the results are typed in below, -1 means predicted.
  // typed bytes read left to right, k0 is the kind of all but the last result
  typedef struct {
    logic [7:0]  pb;
    logic        fb;
    logic        lb;
    logic [15:0] len;
    logic        mk;
    int          n;
    logic [63:0] bytes;
    out_kind_t   k0;
    out_kind_t   kn;
  } stim_row_t;

  // parser state of the predictor
  typedef enum logic [2:0] {PKT_IDLE, PKT_SINGLE, PKT_STAP, PKT_FU, PKT_SKIP} pkt_kind_t;
  typedef enum logic [1:0] {SZ_HIGH, SZ_LOW, IN_UNIT, STAP_DONE} stap_phase_t;

  localparam int FedTarget = 410;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhd_in_if  pkt_in ();
  rhd_out_if strm_out ();

  rtp_h264_depacketizer DUT (
    .clk      (clk),
    .rst      (rst),
    .pkt_in   (pkt_in),
    .strm_out (strm_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  pkt_kind_t   pkt_kind   = PKT_IDLE;
  stap_phase_t stap_phase = SZ_HIGH;
  logic [15:0] pkt_pos    = '0;
  logic [7:0]  size_hi    = '0;
  logic [15:0] unit_left  = '0;
  logic [2:0]  nri        = '0;
  logic        frag_open  = 1'b0;
  logic        frag_end   = 1'b0;
  logic        au_pending = 1'b0;

  strm_beat_t run [$];             // results of the byte being predicted
  strm_beat_t strm_expected [$];   // results still owed by the block
  strm_beat_t head_beat;

  // expectation typed for the byte currently on pkt_in
  int          typed_n = -1;
  logic [63:0] typed_bytes = '0;
  out_kind_t   typed_k0 = KIND_DATA;
  out_kind_t   typed_kn = KIND_DATA;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned fed_items = 0;
  int unsigned mismatches = 0;

  logic [7:0] pkt_body [$];

  // corner cases, walked in order right after reset
  stim_row_t steps [0:25] = '{
    // stray byte with no packet open, its marker is ignored
    '{8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b1, 0, 64'h0, KIND_DATA, KIND_DATA},
    // zero length first byte is dropped
    '{8'h65, 1'b1, 1'b1, 16'h0000, 1'b1, 0, 64'h0, KIND_DATA, KIND_DATA},
    // one byte single nal with marker: start code, byte, access unit end
    '{8'h41, 1'b1, 1'b1, 16'h0001, 1'b1, 6, 64'h00_00_00_01_41_00, KIND_DATA, KIND_AUEND},
    // type 23 at the top of the single range, maximum length
    '{8'h17, 1'b1, 1'b0, 16'hFFFF, 1'b0, 5, 64'h00_00_00_01_17, KIND_DATA, KIND_DATA},
    // last_byte ends it long before the length does
    '{8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b1, 2, 64'hFF_00, KIND_DATA, KIND_AUEND},
    // type 0 is skipped, nothing committed so no access unit end
    '{8'hE0, 1'b1, 1'b1, 16'h0001, 1'b1, 0, 64'h0, KIND_DATA, KIND_DATA},
    // stap-a: one two-byte unit, then a zero size stops the parse
    '{8'h78, 1'b1, 1'b0, 16'h0008, 1'b0, 0, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h00, 1'b0, 1'b0, 16'h0008, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h02, 1'b0, 1'b0, 16'h0008, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'hAA, 1'b0, 1'b0, 16'h0008, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'hBB, 1'b0, 1'b0, 16'h0008, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h00, 1'b0, 1'b0, 16'h0008, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h00, 1'b0, 1'b0, 16'h0008, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    // ends by length with marker set
    '{8'hCC, 1'b0, 1'b0, 16'h0008, 1'b1, -1, 64'h0, KIND_DATA, KIND_DATA},
    // stap-a unit of five cut short by last_byte
    '{8'h18, 1'b1, 1'b0, 16'h0014, 1'b0, 0, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h00, 1'b0, 1'b0, 16'h0014, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h05, 1'b0, 1'b0, 16'h0014, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    '{8'hAA, 1'b0, 1'b1, 16'h0014, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    // fu-a with only the indicator: marker ignored although data is pending
    '{8'h1C, 1'b1, 1'b1, 16'h0001, 1'b1, 0, 64'h0, KIND_DATA, KIND_DATA},
    // fu-a start of a type 5 fragment
    '{8'h7C, 1'b1, 1'b0, 16'h0003, 1'b0, 0, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h85, 1'b0, 1'b0, 16'h0003, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    // new packet before the old one ended, then a restart drops the open fragment
    '{8'hFC, 1'b1, 1'b0, 16'h0003, 1'b0, 0, 64'h0, KIND_DATA, KIND_DATA},
    '{8'hC1, 1'b0, 1'b0, 16'h0003, 1'b0, -1, 64'h0, KIND_DATA, KIND_DATA},
    // end bit: commit, then access unit end on the marker
    '{8'h22, 1'b0, 1'b0, 16'h0003, 1'b1, -1, 64'h0, KIND_DATA, KIND_DATA},
    // fragment left open at the marker is dropped
    '{8'h7C, 1'b1, 1'b0, 16'h0002, 1'b0, 0, 64'h0, KIND_DATA, KIND_DATA},
    '{8'h81, 1'b0, 1'b1, 16'h0002, 1'b1, -1, 64'h0, KIND_DATA, KIND_DATA}
  };

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  function automatic void emit(input logic [7:0] d, input out_kind_t k);
    if (run.size() < MaxResults) run.insert(run.size(), '{d, k, 1'b0});
  endfunction

  function automatic void start_code(input out_kind_t k);
    emit(8'h00, k);
    emit(8'h00, k);
    emit(8'h00, k);
    emit(8'h01, k);
  endfunction

  // advances the parser by one payload byte and leaves its results in run
  function automatic void depacketize(input rtp_byte_t it);
    logic [4:0]  nal;
    logic [15:0] unit_size;
    int unsigned pos;
    bit          ends;
    bit          marker_ok;
    run.delete();
    marker_ok = 1'b1;
    if (it.fb) begin
      pkt_kind = PKT_IDLE;
      pkt_pos  = '0;
      if (it.len == 0) return;
      nal = it.pb[4:0];
      if (nal >= NalSingleMin && nal <= NalSingleMax) pkt_kind = PKT_SINGLE;
      else if (nal == NalStapA) pkt_kind = PKT_STAP;
      else if (nal == NalFuA) pkt_kind = PKT_FU;
      else pkt_kind = PKT_SKIP;
      stap_phase = SZ_HIGH;
      frag_end   = 1'b0;
    end else if (pkt_kind == PKT_IDLE) begin
      return;
    end

    pos  = pkt_pos;
    ends = it.lb || (pos + 1 >= it.len);

    case (pkt_kind)
      PKT_SINGLE: begin
        if (pos == 0) start_code(KIND_DATA);
        emit(it.pb, KIND_DATA);
        au_pending = 1'b1;
      end
      PKT_STAP: begin
        if (pos != 0) begin
          case (stap_phase)
            SZ_HIGH: begin
              size_hi    = it.pb;
              stap_phase = SZ_LOW;
            end
            SZ_LOW: begin
              unit_size = {size_hi, it.pb};
              // zero size, or a unit running past the packet, ends the parse
              if (unit_size == 0 || pos + 1 + unit_size > it.len) begin
                stap_phase = STAP_DONE;
              end else begin
                start_code(KIND_DATA);
                unit_left  = unit_size;
                stap_phase = IN_UNIT;
                au_pending = 1'b1;
              end
            end
            IN_UNIT: begin
              emit(it.pb, KIND_DATA);
              unit_left = unit_left - 1'b1;
              if (unit_left == 0) stap_phase = SZ_HIGH;
            end
            default: ;
          endcase
        end
      end
      PKT_FU: begin
        if (pos == 0) begin
          nri = it.pb[7:5];
          if (ends) marker_ok = 1'b0;
        end else if (pos == 1) begin
          frag_end = it.pb[FuEndBit];
          if (it.pb[FuStartBit]) begin
            if (frag_open) emit(8'h00, KIND_DROP);
            frag_open = 1'b1;
            start_code(KIND_TENT);
            emit({nri, it.pb[4:0]}, KIND_TENT);
          end
        end else if (frag_open) begin
          emit(it.pb, KIND_TENT);
        end
        if (ends && pos >= 1 && frag_end && frag_open) begin
          emit(8'h00, KIND_COMMIT);
          frag_open  = 1'b0;
          au_pending = 1'b1;
        end
      end
      default: ;
    endcase

    if (ends) begin
      if (it.mk && marker_ok) begin
        if (frag_open) begin
          emit(8'h00, KIND_DROP);
          frag_open = 1'b0;
        end
        if (au_pending) begin
          emit(8'h00, KIND_AUEND);
          au_pending = 1'b0;
        end
      end
      pkt_kind = PKT_IDLE;
      frag_end = 1'b0;
      pkt_pos  = '0;
    end else begin
      pkt_pos = pos[15:0] + 16'd1;
    end

    if (run.size() > 0) run[run.size()-1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // monitor: accepted bytes feed the predictor, stream transactions are checked
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst) begin
      // input first, in case a result could leave in the cycle its byte enters
      if (pkt_in.valid && pkt_in.ready) begin
        depacketize('{pkt_in.payload_byte, pkt_in.first_byte, pkt_in.last_byte,
                      pkt_in.payload_length, pkt_in.rtp_marker});
        if (typed_n < 0) begin
          foreach (run[i]) strm_expected.insert(strm_expected.size(), run[i]);
        end else begin
          for (int i = 0; i < typed_n; i++)
            strm_expected.insert(strm_expected.size(),
                                 '{typed_bytes[8*(typed_n-1-i) +: 8],
                                   (i == typed_n - 1) ? typed_kn : typed_k0,
                                   i == typed_n - 1});
        end
      end
      if (strm_out.valid && strm_out.ready) begin
        if (strm_expected.size() == 0) begin
          $error("strm_out: transaction with nothing pending, out_byte %02h out_kind %0d",
                 strm_out.out_byte, strm_out.out_kind);
          mismatches++;
        end else begin
          head_beat = strm_expected.pop_front();
          if (strm_out.out_byte !== head_beat.data) begin
            $error("out_byte: expected %02h, actual %02h", head_beat.data, strm_out.out_byte);
            mismatches++;
          end
          if (strm_out.out_kind !== head_beat.kind) begin
            $error("out_kind: expected %0d, actual %0d", head_beat.kind, strm_out.out_kind);
            mismatches++;
          end
          if (strm_out.run_last !== head_beat.last) begin
            $error("run_last: expected %0b, actual %0b", head_beat.last, strm_out.run_last);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver, stalls at the rate of the current phase
  initial begin
    strm_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      strm_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // sender
  // ------------------------------------------------------------------------

  // presents one byte at the falling edge and holds it until the transaction
  task automatic put_byte(input rtp_byte_t it, input int n, input logic [63:0] bytes,
                          input out_kind_t k0, input out_kind_t kn);
    while ($urandom_range(99) < idle_pct) begin
      pkt_in.valid <= 1'b0;
      @(negedge clk);
    end
    typed_n     = n;
    typed_bytes = bytes;
    typed_k0    = k0;
    typed_kn    = kn;
    pkt_in.valid          <= 1'b1;
    pkt_in.payload_byte   <= it.pb;
    pkt_in.first_byte     <= it.fb;
    pkt_in.last_byte      <= it.lb;
    pkt_in.payload_length <= it.len;
    pkt_in.rtp_marker     <= it.mk;
    do @(posedge clk); while (!(pkt_in.valid && pkt_in.ready));
    fed_items++;
    @(negedge clk);
  endtask

  // sends pkt_body, now and then with a broken length or cut off early
  task automatic send_packet(input bit marker);
    int unsigned n;
    int unsigned len_field;
    int unsigned cut;
    bit          mark_last;
    rtp_byte_t   it;
    n         = pkt_body.size();
    len_field = n;
    cut       = n;
    mark_last = ($urandom_range(3) != 0);
    case ($urandom_range(19))
      0: len_field = $urandom_range(65535, n);   // length overstated
      1: len_field = $urandom_range(n, 1);       // length understated, tail is stray
      2: begin                                   // abandoned by the next packet
        cut       = $urandom_range(n, 1);
        mark_last = 1'b0;
        len_field = n + 1;
      end
      3: len_field = 0;
      default: ;
    endcase
    for (int i = 0; i < cut; i++) begin
      it.pb  = pkt_body[i];
      it.fb  = (i == 0);
      it.lb  = mark_last && (i == cut - 1);
      it.len = len_field[15:0];
      it.mk  = marker;
      put_byte(it, -1, 64'h0, KIND_DATA, KIND_DATA);
    end
  endtask

  // appends one byte to the packet being built
  function automatic void add_body(input logic [7:0] v);
    pkt_body.insert(pkt_body.size(), v);
  endfunction

  function automatic void build_single();
    pkt_body.delete();
    add_body({3'($urandom_range(7)), 5'($urandom_range(23, 1))});
    repeat ($urandom_range(9)) add_body(8'($urandom_range(255)));
  endfunction

  function automatic void build_stap();
    int unsigned sz;
    pkt_body.delete();
    add_body({3'($urandom_range(7)), NalStapA});
    repeat ($urandom_range(3, 1)) begin
      case ($urandom_range(9))
        0: begin   // zero size
          add_body(8'h00);
          add_body(8'h00);
        end
        1: begin   // random size, mostly past the end
          add_body(8'($urandom_range(255)));
          add_body(8'($urandom_range(255)));
        end
        default: begin
          sz = $urandom_range(6, 1);
          add_body(8'h00);
          add_body(8'(sz));
          repeat (sz) add_body(8'($urandom_range(255)));
        end
      endcase
    end
  endfunction

  function automatic void build_fu(input bit s, input bit e);
    pkt_body.delete();
    add_body({3'($urandom_range(7)), NalFuA});
    if ($urandom_range(15) != 0) begin
      add_body({s, e, 1'($urandom_range(1)), 5'($urandom_range(31))});
      repeat ($urandom_range(8)) add_body(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_skip();
    logic [4:0] t;
    pkt_body.delete();
    do t = 5'($urandom_range(31));
    while ((t >= NalSingleMin && t <= NalStapA) || t == NalFuA);
    add_body({3'($urandom_range(7)), t});
    repeat ($urandom_range(4)) add_body(8'($urandom_range(255)));
  endfunction

  initial begin
    rtp_byte_t   it;
    int unsigned n_pk;
    int unsigned nfr;
    bit          mk;
    bit          drained;
    drained = 1'b0;
    pkt_in.valid          = 1'b0;
    pkt_in.payload_byte   = '0;
    pkt_in.first_byte     = 1'b0;
    pkt_in.last_byte      = 1'b0;
    pkt_in.payload_length = '0;
    pkt_in.rtp_marker     = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corner cases, no idling
    foreach (steps[r]) begin
      it = '{steps[r].pb, steps[r].fb, steps[r].lb, steps[r].len, steps[r].mk};
      put_byte(it, steps[r].n, steps[r].bytes, steps[r].k0, steps[r].kn);
    end

    // random access units, idling phases follow the byte count
    while (fed_items < FedTarget) begin
      if (fed_items < 70) begin
        idle_pct = 0;  stall_pct = 0;
      end else if (fed_items < 160) begin
        idle_pct = 59; stall_pct = 0;
      end else if (fed_items < 250) begin
        idle_pct = 0;  stall_pct = 59;
      end else if (fed_items < 340) begin
        idle_pct = 20; stall_pct = 20;
      end else begin
        idle_pct = 0;  stall_pct = 0;
      end

      // hold off once until the block has delivered everything
      if (fed_items >= 340 && !drained) begin
        pkt_in.valid <= 1'b0;
        do @(negedge clk); while (strm_expected.size() != 0);
        drained = 1'b1;
      end

      n_pk = $urandom_range(4, 1);
      for (int p = 0; p < n_pk; p++) begin
        // marker mostly on the last packet of the access unit
        mk = (p == n_pk - 1) ? ($urandom_range(4) != 0) : ($urandom_range(9) == 0);
        case ($urandom_range(9))
          0, 1, 2: begin
            build_single();
            send_packet(mk);
          end
          3, 4: begin
            build_stap();
            send_packet(mk);
          end
          5, 6, 7: begin
            // fragmented unit: start, middles, end, with an odd restart
            nfr = $urandom_range(3, 1);
            for (int f = 0; f < nfr; f++) begin
              build_fu(f == 0 || $urandom_range(7) == 0,
                       (f == nfr - 1) && $urandom_range(5) != 0);
              send_packet((f == nfr - 1) ? mk : 1'b0);
            end
          end
          8: begin
            build_skip();
            send_packet(mk);
          end
          default: begin
            // stray bytes with no first flag
            repeat ($urandom_range(3, 1)) begin
              it.pb  = 8'($urandom_range(255));
              it.fb  = 1'b0;
              it.lb  = 1'($urandom_range(1));
              it.len = 16'($urandom_range(65535));
              it.mk  = 1'($urandom_range(1));
              put_byte(it, -1, 64'h0, KIND_DATA, KIND_DATA);
            end
          end
        endcase
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    pkt_in.valid <= 1'b0;
    while (strm_expected.size() != 0) @(posedge clk);
    // room for any stray transaction after the last expected one
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
